### design/mmfp_pkg.sv
// Shared constants, state encoding and controller/datapath struct types
// for the max-min fair pour allocator. No dependencies.
`default_nettype none
package mmfp_pkg;
   localparam int MaxSources = 16;
   localparam int RateWidth  = 16;
   localparam int FieldW     = 16;
   localparam int IndexW     = 4;
   localparam int StoreW     = (RateWidth < FieldW) ? RateWidth : FieldW;
   localparam int IdxW       = (MaxSources > 1) ? $clog2(MaxSources) : 1;
   localparam int CntW       = $clog2(MaxSources + 1);
   localparam int BitW       = $clog2(StoreW);
   localparam int SumW       = StoreW + CntW;
   localparam int CmpW       = (SumW > FieldW) ? SumW : FieldW;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SEARCH,
      ST_COMMIT,
      ST_FINAL,
      ST_FINISH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic            load;
      logic            accum;
      logic            first;
      logic            final_pass;
      logic            commit;
      logic            finish;
      logic            emit;
      logic            last_emit;
      logic [IdxW-1:0] idx;
      logic [BitW-1:0] bit_sel;
   } cmd_type;

   typedef struct packed {
      logic [CntW-1:0] count;
      logic            out_free;
   } status_type;
endpackage
`default_nettype wire

### design/mmfp_channels.sv
// Valid/ready channel interfaces: request, response and capacity write.
// Depends on mmfp_pkg for field widths.
`default_nettype none
interface mmfp_req_if;
   logic                        valid;
   logic                        ready;
   logic [mmfp_pkg::FieldW-1:0] request_rate;
   logic                        last_request;
   modport source (output valid, output request_rate, output last_request, input ready);
   modport sink (input valid, input request_rate, input last_request, output ready);
endinterface

interface mmfp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mmfp_pkg::FieldW-1:0] allocation;
   logic [mmfp_pkg::IndexW-1:0] source_index;
   logic [mmfp_pkg::FieldW-1:0] leftover;
   logic                        overflowed;
   logic                        last_result;
   modport source (output valid, output allocation, output source_index, output leftover,
                   output overflowed, output last_result, input ready);
   modport sink (input valid, input allocation, input source_index, input leftover,
                 input overflowed, input last_result, output ready);
endinterface

interface mmfp_csr_if;
   logic                        valid;
   logic                        ready;
   logic [mmfp_pkg::FieldW-1:0] capacity;
   modport source (output valid, output capacity, input ready);
   modport sink (input valid, input capacity, output ready);
endinterface
`default_nettype wire

### design/mmfp_ctrl.sv
// Sequencer: load, per-bit level search walks, final pass, finish, emit.
// Depends on mmfp_pkg; drives mmfp_datapath through cmd_type.
`default_nettype none
module mmfp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_last,
   output logic                      req_ready,
   input  wire mmfp_pkg::status_type sts,
   output mmfp_pkg::cmd_type         cmd,
   output mmfp_pkg::state_type       state
);
   import mmfp_pkg::*;

   state_type       state_ff, state_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [BitW-1:0] bit_ff, bit_in;
   logic            last_idx;

   assign last_idx = (CntW'(idx_ff) == (sts.count - CntW'(1)));
   assign state    = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         idx_ff   <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         bit_ff   <= bit_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (last_idx) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = (bit_ff == '0) ? ST_FINAL : ST_SEARCH;
         end
         ST_FINAL: begin
            if (last_idx) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free && last_idx) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.idx     = idx_ff;
      cmd.bit_sel = bit_ff;
      cmd.first   = (idx_ff == '0);
      req_ready   = 1'b0;
      idx_in      = idx_ff;
      bit_in      = bit_ff;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            idx_in    = '0;
            bit_in    = BitW'(StoreW - 1);
         end
         ST_SEARCH: begin
            cmd.accum = 1'b1;
            idx_in    = last_idx ? '0 : idx_ff + IdxW'(1);
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            if (bit_ff != '0) bit_in = bit_ff - BitW'(1);
         end
         ST_FINAL: begin
            cmd.accum      = 1'b1;
            cmd.final_pass = 1'b1;
            idx_in         = last_idx ? '0 : idx_ff + IdxW'(1);
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            idx_in     = '0;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.last_emit = last_idx;
               idx_in        = last_idx ? '0 : idx_ff + IdxW'(1);
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end
endmodule
`default_nettype wire

### design/mmfp_datapath.sv
// Request store, level search accumulators, grant/leftover math and the
// response register. Depends on mmfp_pkg; commanded by mmfp_ctrl.
`default_nettype none
module mmfp_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mmfp_pkg::cmd_type           cmd,
   output mmfp_pkg::status_type             sts,
   input  wire logic [mmfp_pkg::FieldW-1:0] req_rate,
   input  wire logic                        csr_write,
   input  wire logic [mmfp_pkg::FieldW-1:0] csr_capacity,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [mmfp_pkg::FieldW-1:0]      rsp_allocation,
   output logic [mmfp_pkg::IndexW-1:0]      rsp_source_index,
   output logic [mmfp_pkg::FieldW-1:0]      rsp_leftover,
   output logic                             rsp_overflowed,
   output logic                             rsp_last_result
);
   import mmfp_pkg::*;

   logic [StoreW-1:0] store_ff [MaxSources];
   logic [CntW-1:0]   count_ff, count_in;
   logic              dropped_ff, dropped_in;
   logic [FieldW-1:0] cap_ff;
   logic [StoreW-1:0] level_ff;
   logic [SumW-1:0]   acc_ff;
   logic [CntW-1:0]   gt_ff;
   logic [FieldW-1:0] extra_ff;
   logic [FieldW-1:0] given_ff;
   logic [FieldW-1:0] left_ff;
   logic              valid_ff;
   logic [FieldW-1:0] alloc_ff;
   logic [IndexW-1:0] index_ff;
   logic              ovf_ff;
   logic              last_ff;

   logic [StoreW-1:0] rd;
   logic [StoreW-1:0] trial;
   logic [StoreW-1:0] clip;
   logic              above;
   logic [FieldW-1:0] rem;
   logic [FieldW-1:0] extra;
   logic              bump;

   assign rd    = store_ff[cmd.idx];
   assign trial = cmd.final_pass ? level_ff : (level_ff | (StoreW'(1) << cmd.bit_sel));
   assign above = (rd > trial);
   assign clip  = above ? trial : rd;
   assign rem   = cap_ff - FieldW'(acc_ff);
   assign extra = (rem < FieldW'(gt_ff)) ? rem : FieldW'(gt_ff);
   assign bump  = (rd > level_ff) && (given_ff < extra_ff);

   assign sts.count    = count_ff;
   assign sts.out_free = !valid_ff || rsp_ready;

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.load) begin
         if (count_ff < CntW'(MaxSources)) count_in = count_ff + CntW'(1);
         else dropped_in = 1'b1;
      end
      if (cmd.emit && cmd.last_emit) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         cap_ff     <= '0;
         valid_ff   <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         if (csr_write) cap_ff <= csr_capacity;
         if (cmd.emit) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < CntW'(MaxSources)))
         store_ff[count_ff[IdxW-1:0]] <= StoreW'(req_rate);
      if (cmd.load) level_ff <= '0;
      if (cmd.accum) begin
         acc_ff <= (cmd.first ? '0 : acc_ff) + SumW'(clip);
         gt_ff  <= (cmd.first ? '0 : gt_ff) + CntW'(above);
      end
      if (cmd.commit && (CmpW'(acc_ff) <= CmpW'(cap_ff))) level_ff <= trial;
      if (cmd.finish) begin
         extra_ff <= extra;
         left_ff  <= rem - extra;
         given_ff <= '0;
      end
      if (cmd.emit) begin
         alloc_ff <= FieldW'((rd > level_ff) ? level_ff : rd) + FieldW'(bump);
         index_ff <= IndexW'(cmd.idx);
         ovf_ff   <= dropped_ff;
         last_ff  <= cmd.last_emit;
         given_ff <= given_ff + FieldW'(bump);
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_allocation   = alloc_ff;
   assign rsp_source_index = index_ff;
   assign rsp_leftover     = left_ff;
   assign rsp_overflowed   = ovf_ff;
   assign rsp_last_result  = last_ff;
endmodule
`default_nettype wire

### design/max_min_fair_pour_allocator_unit.sv
// Top level of the max-min fair pour allocator: controller plus datapath.
// Depends on mmfp_pkg, mmfp_channels, mmfp_ctrl and mmfp_datapath.
//
// Request words load one source each, one per cycle, into a 16-entry store;
// words past the limit are dropped and flagged, and a marked last word starts
// the run. The fill level is found by a bit-serial search over the 16 level
// bits, each bit costing one walk over the n stored sources plus a commit
// step, then one more walk and a finish step settle the partial round. Results
// follow as n response words at one per cycle while the output is taken.
// No request is taken during a run.
`default_nettype none
module max_min_fair_pour_allocator_unit (
   input  wire logic clock,
   input  wire logic reset,
   mmfp_req_if.sink   req_port,
   mmfp_rsp_if.source rsp_port,
   mmfp_csr_if.sink   csr_port
);
   import mmfp_pkg::*;

   cmd_type    cmd;
   status_type sts;
   state_type  state;
   logic       req_ready;

   assign req_port.ready = req_ready;
   assign csr_port.ready = 1'b1;

   mmfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_last  (req_port.last_request),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd),
      .state     (state)
   );

   mmfp_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_rate         (req_port.request_rate),
      .csr_write        (csr_port.valid),
      .csr_capacity     (csr_port.capacity),
      .rsp_valid        (rsp_port.valid),
      .rsp_ready        (rsp_port.ready),
      .rsp_allocation   (rsp_port.allocation),
      .rsp_source_index (rsp_port.source_index),
      .rsp_leftover     (rsp_port.leftover),
      .rsp_overflowed   (rsp_port.overflowed),
      .rsp_last_result  (rsp_port.last_result)
   );

`ifndef SYNTHESIS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free) else $error("emit while response held");
   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last_emit) |=> (sts.count == '0)) else $error("set not cleared");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (state != ST_LOAD) |-> !cmd.load) else $error("load during run");
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state == ST_SEARCH) |-> (sts.count != '0)) else $error("empty run");
`endif
endmodule
`default_nettype wire
